>>> src/srbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srbt_pkg
// Shared types, constants and helpers of the stream ring buffer tracker.
// ----------------------------------------------------------------------------
package srbt_pkg;

    localparam int NUM_STREAMS      = 8;
    localparam int IDX_W            = $clog2(NUM_STREAMS);
    localparam int MAX_BUFFER_BYTES = 65536;

    localparam int FL_ALLOC = 0;
    localparam int FL_PLAY  = 1;
    localparam int FL_LOCK  = 2;

    typedef enum logic [3:0] {
        OP_ALLOC   = 4'd0,
        OP_FREE    = 4'd1,
        OP_PREPARE = 4'd2,
        OP_PLAY    = 4'd3,
        OP_STOP    = 4'd4,
        OP_FLAGS   = 4'd5,
        OP_SPACE   = 4'd6,
        OP_LOCK    = 4'd7,
        OP_UNLOCK  = 4'd8
    } op_t;

    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_BAD_INDEX   = 3'd1,
        STAT_ALLOCATED   = 3'd2,
        STAT_PLAYING     = 3'd3,
        STAT_NOT_ALLOC   = 3'd4,
        STAT_NOT_PLAYING = 3'd5,
        STAT_LOCKED      = 3'd6,
        STAT_NOT_LOCKED  = 3'd7
    } stat_t;

    // per-stream record held in the state memory
    typedef struct packed {
        logic [16:0]        size;
        logic [16:0]        woff;
        logic [16:0]        poff;
        logic signed [18:0] pend;
        logic [16:0]        llen;
    } rec_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [2:0]  stream;
        logic [16:0] buffer_size;
        logic [16:0] requested_bytes;
        logic [15:0] played_offset;
    } item_t;

    typedef struct packed {
        stat_t              status;
        logic [2:0]         flags_out;
        logic signed [18:0] free_bytes;
        logic [15:0]        lock_offset;
        logic [16:0]        lock_length;
    } result_t;

    typedef struct packed {
        logic mem_we;
        logic cnt_inc;
        logic cnt_dec;
    } ctl_t;

    function automatic logic signed [18:0] sat19(input logic signed [20:0] v);
        logic signed [18:0] r;
        if (v > 21'sd262143)
            r = 19'sd262143;
        else if (v < -21'sd262144)
            r = -19'sd262144;
        else
            r = v[18:0];
        return r;
    endfunction

endpackage

>>> src/srbt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srbt_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module srbt_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/srbt_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srbt_alu
// Checks one operation against the stream flags and computes the new
// record, the new flags and the result of the transaction.
// ----------------------------------------------------------------------------
module srbt_alu
    import srbt_pkg::*;
(
    input  item_t       item,
    input  logic [3:0]  stream_count,
    input  logic [2:0]  flags,
    input  rec_t        rec,
    output rec_t        rec_n,
    output logic [2:0]  flags_n,
    output result_t     res,
    output ctl_t        ctl
);

    logic               idx_ok;
    logic               known;
    logic               f_alloc;
    logic               f_play;
    logic               f_lock;
    logic [16:0]        played;
    logic signed [20:0] pend_ext;
    logic signed [20:0] size_ext;
    logic signed [20:0] po_ext;
    logic signed [20:0] pl_ext;
    logic signed [20:0] delta;
    logic signed [18:0] pend_space;
    logic signed [20:0] pend_space_ext;
    logic signed [18:0] free_space;
    logic [17:0]        lock_end;
    logic [16:0]        grant;
    logic [17:0]        wsum;
    logic [17:0]        wwrap;
    logic signed [18:0] pend_unlock;
    logic [16:0]        bsize_sat;

    assign idx_ok  = 4'(item.stream) < stream_count;
    assign known   = item.kind <= OP_UNLOCK;
    assign f_alloc = flags[FL_ALLOC];
    assign f_play  = flags[FL_PLAY];
    assign f_lock  = flags[FL_LOCK];
    assign played  = {1'b0, item.played_offset};

    // free space query
    assign pend_ext = {{2{rec.pend[18]}}, rec.pend};
    assign size_ext = {4'b0, rec.size};
    assign po_ext   = {4'b0, rec.poff};
    assign pl_ext   = {4'b0, played};

    always_comb
    begin
        if (rec.poff < played)
            delta = pl_ext - po_ext;
        else if (rec.poff != played)
            delta = size_ext - po_ext + pl_ext;
        else
            delta = '0;
    end

    assign pend_space     = sat19(pend_ext - delta);
    assign pend_space_ext = {{2{pend_space[18]}}, pend_space};
    assign free_space     = sat19(size_ext - pend_space_ext);

    // lock clipping at buffer end
    assign lock_end = {1'b0, rec.woff} + {1'b0, item.requested_bytes};

    always_comb
    begin
        if (rec.woff > rec.size)
            grant = '0;
        else if (lock_end > {1'b0, rec.size})
            grant = rec.size - rec.woff;
        else
            grant = item.requested_bytes;
    end

    // unlock advance with wrap
    assign wsum        = {1'b0, rec.woff} + {1'b0, rec.llen};
    assign wwrap       = (wsum >= {1'b0, rec.size}) ? wsum - {1'b0, rec.size} : wsum;
    assign pend_unlock = sat19(pend_ext + {4'b0, rec.llen});

    assign bsize_sat = (item.buffer_size > 17'(MAX_BUFFER_BYTES)) ?
                       17'(MAX_BUFFER_BYTES) : item.buffer_size;

    always_comb
    begin
        rec_n   = rec;
        flags_n = flags;
        res     = '0;
        ctl     = '0;
        if (known && !idx_ok)
        begin
            res.status = STAT_BAD_INDEX;
        end
        else if (known)
        begin
            case (op_t'(item.kind))
                OP_ALLOC:
                begin
                    if (f_alloc)
                        res.status = STAT_ALLOCATED;
                    else if (f_play)
                        res.status = STAT_PLAYING;
                    else
                    begin
                        rec_n.size        = bsize_sat;
                        rec_n.woff        = '0;
                        rec_n.poff        = '0;
                        rec_n.pend        = '0;
                        flags_n[FL_ALLOC] = 1'b1;
                        ctl.mem_we        = 1'b1;
                        ctl.cnt_inc       = 1'b1;
                    end
                end
                OP_FREE:
                begin
                    if (!f_alloc)
                        res.status = STAT_NOT_ALLOC;
                    else
                    begin
                        flags_n[FL_ALLOC] = 1'b0;
                        flags_n[FL_PLAY]  = 1'b0;
                        ctl.cnt_dec       = 1'b1;
                    end
                end
                OP_PREPARE:
                begin
                    if (!f_alloc)
                        res.status = STAT_NOT_ALLOC;
                    else if (f_play)
                        res.status = STAT_PLAYING;
                    else
                    begin
                        rec_n.woff = '0;
                        rec_n.poff = '0;
                        rec_n.pend = '0;
                        ctl.mem_we = 1'b1;
                    end
                end
                OP_PLAY:
                begin
                    if (!f_alloc)
                        res.status = STAT_NOT_ALLOC;
                    else if (f_play)
                        res.status = STAT_PLAYING;
                    else
                        flags_n[FL_PLAY] = 1'b1;
                end
                OP_STOP:
                begin
                    if (!f_alloc)
                        res.status = STAT_NOT_ALLOC;
                    else if (!f_play)
                        res.status = STAT_NOT_PLAYING;
                    else
                        flags_n[FL_PLAY] = 1'b0;
                end
                OP_FLAGS:
                begin
                    res.status = STAT_OK;
                end
                OP_SPACE:
                begin
                    if (!f_alloc)
                        res.status = STAT_NOT_ALLOC;
                    else
                    begin
                        rec_n.poff = played;
                        ctl.mem_we = 1'b1;
                        if (rec.pend < 0)
                        begin
                            rec_n.pend     = '0;
                            res.free_bytes = {2'b0, rec.size};
                        end
                        else
                        begin
                            rec_n.pend     = pend_space;
                            res.free_bytes = free_space;
                        end
                    end
                end
                OP_LOCK:
                begin
                    if (!f_alloc)
                        res.status = STAT_NOT_ALLOC;
                    else if (f_lock)
                        res.status = STAT_LOCKED;
                    else
                    begin
                        rec_n.llen       = grant;
                        flags_n[FL_LOCK] = 1'b1;
                        ctl.mem_we       = 1'b1;
                        res.lock_offset  = rec.woff[15:0];
                        res.lock_length  = grant;
                    end
                end
                OP_UNLOCK:
                begin
                    if (!f_alloc)
                        res.status = STAT_NOT_ALLOC;
                    else if (!f_lock)
                        res.status = STAT_NOT_LOCKED;
                    else
                    begin
                        rec_n.woff       = wwrap[16:0];
                        rec_n.pend       = pend_unlock;
                        flags_n[FL_LOCK] = 1'b0;
                        ctl.mem_we       = 1'b1;
                    end
                end
                default:
                begin
                    res.status = STAT_OK;
                end
            endcase
            res.flags_out = flags_n;
        end
        else if (idx_ok)
        begin
            res.flags_out = flags;
        end
    end

endmodule

>>> src/stream_ring_buffer_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_ring_buffer_tracker
// Bookkeeping of up to eight audio stream ring buffers: allocation, play and
// lock flags, write and play offsets, pending byte count and lock length.
// ----------------------------------------------------------------------------
// usage
//   s_* carries one operation per transaction: kind in s_tuser, the stream
//   index and operands in s_tdata. m_* returns exactly one result per
//   operation: status in m_tuser, flags, free space, lock grant and the
//   allocated total in m_tdata. cfg_* writes stream_count (indices below
//   it are valid); write it only while no operation is in flight.
//   An accepted operation has its stream record read from the state memory
//   at the accepting edge, then executes and writes back in the execute
//   state once the output register is free; the result is registered at
//   that write-back. A new operation is accepted only in idle, after the
//   previous one has written back.
//   Reset clears all flags and the allocated total and sets stream_count to
//   eight; records are written on allocation and need no clearing.
//   When m_tready is low the result is held in the output register; the
//   next operation is still accepted and waits in its execute cycle until
//   the output register frees up.
// ----------------------------------------------------------------------------
module stream_ring_buffer_tracker
    import srbt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // stream[2:0], buffer_size[19:3], requested_bytes[36:20], played_offset[52:37]
    input  logic [55:0] s_tdata,
    // kind[3:0]
    input  logic [3:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // flags_out[2:0], free_bytes[21:3], lock_offset[37:22], lock_length[54:38],
    // allocated_total[58:55]
    output logic [63:0] m_tdata,
    // status[2:0]
    output logic [2:0]  m_tuser
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t         state_reg;
    state_t         state_next;
    logic [3:0]     stream_count_reg;
    logic [2:0]     flags_reg [NUM_STREAMS];
    logic [3:0]     count_reg;
    logic [3:0]     count_next;
    item_t          item_reg;
    result_t        res_reg;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic           accept;
    logic           out_free;
    logic           commit;
    logic [$bits(rec_t)-1:0] rd_data;
    rec_t           rec;
    rec_t           rec_n;
    logic [2:0]     flags_n;
    result_t        res;
    ctl_t           ctl;
    logic [NUM_STREAMS-1:0] alloc_vec;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign commit    = (state_reg == ST_EXEC) && out_free;

    srbt_ram #(
        .DEPTH (NUM_STREAMS),
        .WIDTH ($bits(rec_t))
    ) u_ram (
        .clk   (clk),
        .we    (commit && ctl.mem_we),
        .waddr (item_reg.stream[IDX_W-1:0]),
        .wdata (rec_n),
        .re    (accept),
        .raddr (s_tdata[IDX_W-1:0]),
        .rdata (rd_data)
    );

    assign rec = rec_t'(rd_data);

    srbt_alu u_alu (
        .item         (item_reg),
        .stream_count (stream_count_reg),
        .flags        (flags_reg[item_reg.stream[IDX_W-1:0]]),
        .rec          (rec),
        .rec_n        (rec_n),
        .flags_n      (flags_n),
        .res          (res),
        .ctl          (ctl)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (commit)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (commit && ctl.cnt_inc)
            count_next = count_reg + 4'd1;
        else if (commit && ctl.cnt_dec)
            count_next = count_reg - 4'd1;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            stream_count_reg <= 4'd8;
            count_reg        <= '0;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < NUM_STREAMS; i++)
                flags_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                stream_count_reg <= cfg_data;
            if (commit)
                flags_reg[item_reg.stream[IDX_W-1:0]] <= flags_n;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= {s_tuser, s_tdata[2:0], s_tdata[19:3],
                         s_tdata[36:20], s_tdata[52:37]};
        if (commit)
            res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.status;
    assign m_tdata  = {5'b0, count_reg, res_reg.lock_length, res_reg.lock_offset,
                       res_reg.free_bytes, res_reg.flags_out};

    always_comb
    begin
        for (int i = 0; i < NUM_STREAMS; i++)
            alloc_vec[i] = flags_reg[i][FL_ALLOC];
    end

`ifndef NO_ASSERTIONS
    a_count_matches_flags: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(alloc_vec) == 32'(count_reg))
        else $error("allocated total out of step with allocated flags");

    a_commit_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> m_tvalid)
        else $error("executed operation produced no result");

    a_write_only_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.mem_we && commit) |-> (state_reg == ST_EXEC))
        else $error("state memory written outside execute");

    a_exec_waits_for_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && !out_free) |=> (state_reg == ST_EXEC))
        else $error("operation dropped while output register was full");
`endif

endmodule

>>> bench/stream_ring_buffer_tracker_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_ring_buffer_tracker_test
// Self-checking bench for the ring buffer tracker. A short directed run walks
// through every operation and every error status but a bad index, oversized
// allocation, pending count saturation, free space with wrap and with a
// negative count, lock clipping and free or realloc while locked. Random phases
// under several stream_count settings follow, mostly well-formed per-stream
// sessions plus raw noise. A cycle-free tracker model predicts each result,
// and the results are checked in order, field by field, with random gaps on both sides.
// ----------------------------------------------------------------------------
module stream_ring_buffer_tracker_test;
    import srbt_pkg::*;

    typedef struct {
        stat_t              status;
        logic [2:0]         flags;
        logic signed [18:0] free_bytes;
        logic [15:0]        lock_offset;
        logic [16:0]        lock_length;
        logic [3:0]         total;
    } outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_data = 4'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // stream[2:0], buffer_size[19:3], requested_bytes[36:20], played_offset[52:37]
    logic [55:0] s_tdata = '0;
    // kind[3:0]
    logic [3:0]  s_tuser = 4'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // flags_out[2:0], free_bytes[21:3], lock_offset[37:22], lock_length[54:38],
    // allocated_total[58:55]
    logic [63:0] m_tdata;
    // status[2:0]
    logic [2:0]  m_tuser;

    item_t    ops_waiting[$];
    outcome_t outcomes_due[$];
    outcome_t due;
    item_t    op_now = '0;
    logic     op_active = 1'b0;
    logic     op_taken = 1'b0;
    logic     res_taken = 1'b0;
    logic     stall_request = 1'b0;
    int       send_gap = 0;
    int       recv_gap = 0;
    int       stall_left = 0;
    int       max_wait = 8;
    int       error_count = 0;

    // tracker model state
    logic [2:0]  trk_flags[NUM_STREAMS];
    int unsigned trk_size[NUM_STREAMS];
    int unsigned trk_woff[NUM_STREAMS];
    int unsigned trk_poff[NUM_STREAMS];
    int          trk_pend[NUM_STREAMS];
    int unsigned trk_llen[NUM_STREAMS];
    int unsigned trk_alloc_count = 0;
    int unsigned trk_stream_count = 8;

    always #1 clk = ~clk;

    stream_ring_buffer_tracker DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    function automatic int clamp_pend(longint v);
        int r;
        if (v > 262143)
        begin
            r = 262143;
        end
        else if (v < -262144)
        begin
            r = -262144;
        end
        else
        begin
            r = int'(v);
        end
        return r;
    endfunction

    function automatic outcome_t apply_op(item_t it);
        outcome_t    r;
        int unsigned lim;
        int unsigned s;
        int unsigned w;
        int unsigned g;
        longint      p;
        logic        is_alloc;
        logic        is_play;
        logic        is_lock;
        r.status      = STAT_OK;
        r.flags       = '0;
        r.free_bytes  = '0;
        r.lock_offset = '0;
        r.lock_length = '0;
        lim = (trk_stream_count < NUM_STREAMS) ? trk_stream_count : NUM_STREAMS;
        s   = 32'(it.stream);
        if (it.kind > OP_UNLOCK)
        begin
            if (s < lim)
            begin
                r.flags = trk_flags[s];
            end
        end
        else if (s >= lim)
        begin
            r.status = STAT_BAD_INDEX;
        end
        else
        begin
            is_alloc = trk_flags[s][FL_ALLOC];
            is_play  = trk_flags[s][FL_PLAY];
            is_lock  = trk_flags[s][FL_LOCK];
            case (it.kind)
                OP_ALLOC:
                begin
                    if (is_alloc)
                        r.status = STAT_ALLOCATED;
                    else if (is_play)
                        r.status = STAT_PLAYING;
                    else
                    begin
                        trk_size[s] = (it.buffer_size > MAX_BUFFER_BYTES) ?
                                      MAX_BUFFER_BYTES : 32'(it.buffer_size);
                        trk_woff[s] = 0;
                        trk_poff[s] = 0;
                        trk_pend[s] = 0;
                        trk_alloc_count++;
                        trk_flags[s][FL_ALLOC] = 1'b1;
                    end
                end
                OP_FREE:
                begin
                    if (!is_alloc)
                        r.status = STAT_NOT_ALLOC;
                    else
                    begin
                        trk_alloc_count--;
                        trk_flags[s][FL_ALLOC] = 1'b0;
                        trk_flags[s][FL_PLAY]  = 1'b0;
                    end
                end
                OP_PREPARE:
                begin
                    if (!is_alloc)
                        r.status = STAT_NOT_ALLOC;
                    else if (is_play)
                        r.status = STAT_PLAYING;
                    else
                    begin
                        trk_woff[s] = 0;
                        trk_poff[s] = 0;
                        trk_pend[s] = 0;
                    end
                end
                OP_PLAY:
                begin
                    if (!is_alloc)
                        r.status = STAT_NOT_ALLOC;
                    else if (is_play)
                        r.status = STAT_PLAYING;
                    else
                        trk_flags[s][FL_PLAY] = 1'b1;
                end
                OP_STOP:
                begin
                    if (!is_alloc)
                        r.status = STAT_NOT_ALLOC;
                    else if (!is_play)
                        r.status = STAT_NOT_PLAYING;
                    else
                        trk_flags[s][FL_PLAY] = 1'b0;
                end
                OP_SPACE:
                begin
                    if (!is_alloc)
                        r.status = STAT_NOT_ALLOC;
                    else if (trk_pend[s] < 0)
                    begin
                        // overrun: restart counting from the mixer position
                        trk_pend[s]  = 0;
                        trk_poff[s]  = 32'(it.played_offset);
                        r.free_bytes = 19'(trk_size[s]);
                    end
                    else
                    begin
                        p = trk_pend[s];
                        if (trk_poff[s] < it.played_offset)
                            p = p - (longint'(it.played_offset) - longint'(trk_poff[s]));
                        else if (trk_poff[s] != it.played_offset)
                            p = p - ((longint'(trk_size[s]) - longint'(trk_poff[s]))
                                     + longint'(it.played_offset));
                        trk_pend[s]  = clamp_pend(p);
                        trk_poff[s]  = 32'(it.played_offset);
                        r.free_bytes = 19'(clamp_pend(longint'(trk_size[s]) - trk_pend[s]));
                    end
                end
                OP_LOCK:
                begin
                    if (!is_alloc)
                        r.status = STAT_NOT_ALLOC;
                    else if (is_lock)
                        r.status = STAT_LOCKED;
                    else
                    begin
                        w = trk_woff[s];
                        g = 32'(it.requested_bytes);
                        if (w > trk_size[s])
                            g = 0;
                        else if (w + g > trk_size[s])
                            g = trk_size[s] - w;
                        trk_llen[s]   = g;
                        r.lock_offset = w[15:0];
                        r.lock_length = g[16:0];
                        trk_flags[s][FL_LOCK] = 1'b1;
                    end
                end
                OP_UNLOCK:
                begin
                    if (!is_alloc)
                        r.status = STAT_NOT_ALLOC;
                    else if (!is_lock)
                        r.status = STAT_NOT_LOCKED;
                    else
                    begin
                        w = trk_woff[s] + trk_llen[s];
                        if (w >= trk_size[s])
                            w = w - trk_size[s];
                        trk_woff[s] = w;
                        trk_pend[s] = clamp_pend(longint'(trk_pend[s]) + trk_llen[s]);
                        trk_flags[s][FL_LOCK] = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
            r.flags = trk_flags[s];
        end
        r.total = trk_alloc_count[3:0];
        return r;
    endfunction

    function automatic logic [55:0] pack_op(item_t it);
        return {3'b000, it.played_offset, it.requested_bytes, it.buffer_size, it.stream};
    endfunction

    function automatic int unsigned pick_req(int unsigned sz);
        int unsigned r;
        if ($urandom_range(0, 4) == 0)
            r = $urandom_range(0, 131071);
        else
            r = $urandom_range(0, sz + sz / 2 + 1);
        return r;
    endfunction

    function automatic int unsigned pick_played(int unsigned sz);
        int unsigned r;
        if (sz == 0 || $urandom_range(0, 4) == 0)
            r = $urandom_range(0, 65535);
        else
            r = $urandom_range(0, sz - 1);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        error_count++;
        $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic add_op(logic [3:0] k, int unsigned s, int unsigned bsize,
                          int unsigned req, int unsigned played);
        item_t it;
        it.kind            = k;
        it.stream          = s[2:0];
        it.buffer_size     = bsize[16:0];
        it.requested_bytes = req[16:0];
        it.played_offset   = played[15:0];
        ops_waiting.push_back(it);
    endtask

    // one stream's life: alloc, lock/unlock/space rounds, maybe free
    task automatic add_session(int unsigned lim);
        int unsigned s;
        int unsigned bsize;
        int unsigned sz;
        int          rounds;
        s = $urandom_range(0, lim - 1);
        case ($urandom_range(0, 9))
            0:       bsize = $urandom_range(0, 131071);
            1:       bsize = MAX_BUFFER_BYTES;
            2:       bsize = 0;
            default: bsize = $urandom_range(1, 1024);
        endcase
        sz = (bsize > MAX_BUFFER_BYTES) ? MAX_BUFFER_BYTES : bsize;
        if ($urandom_range(0, 4) != 0)
            add_op(OP_ALLOC, s, bsize, $urandom, $urandom);
        if ($urandom_range(0, 3) == 0)
            add_op(OP_PREPARE, s, $urandom, $urandom, $urandom);
        rounds = $urandom_range(1, 5);
        repeat (rounds)
        begin
            if ($urandom_range(0, 3) == 0)
                add_op(OP_PLAY, s, $urandom, $urandom, $urandom);
            add_op(OP_LOCK, s, $urandom, pick_req(sz), $urandom);
            if ($urandom_range(0, 7) != 0)
                add_op(OP_UNLOCK, s, $urandom, $urandom, $urandom);
            if ($urandom_range(0, 5) == 0)
                add_op(OP_FLAGS, s, $urandom, $urandom, $urandom);
            add_op(OP_SPACE, s, $urandom, $urandom, pick_played(sz));
            if ($urandom_range(0, 3) == 0)
                add_op(OP_STOP, s, $urandom, $urandom, $urandom);
        end
        if ($urandom_range(0, 1) == 0)
            add_op(OP_FREE, s, $urandom, $urandom, $urandom);
    endtask

    task automatic add_random_ops(int unsigned n, int unsigned lim);
        int unsigned target;
        target = ops_waiting.size() + n;
        while (ops_waiting.size() < target)
        begin
            if (lim == 0 || $urandom_range(0, 5) == 0)
                add_op(4'($urandom_range(0, 15)), $urandom_range(0, 7),
                       $urandom_range(0, 131071), $urandom_range(0, 131071),
                       $urandom_range(0, 65535));
            else
                add_session(lim);
        end
    endtask

    task automatic wait_drained();
        while (ops_waiting.size() != 0 || op_active || outcomes_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_stream_count(logic [3:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        trk_stream_count = 32'(v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // sender
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (op_active && op_taken)
            begin
                op_active = 1'b0;
                send_gap  = $urandom_range(0, max_wait);
            end
            op_taken = 1'b0;
            if (!op_active)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (ops_waiting.size() > 0)
                begin
                    op_now    = ops_waiting.pop_front();
                    op_active = 1'b1;
                end
            end
        end
        s_tvalid <= op_active;
        s_tdata  <= pack_op(op_now);
        s_tuser  <= op_now.kind;
    end

    // receiver
    always @(negedge clk)
    begin
        if (stall_request)
        begin
            stall_left    = 300;
            stall_request = 1'b0;
        end
        if (res_taken)
        begin
            recv_gap  = $urandom_range(0, max_wait);
            res_taken = 1'b0;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // result check first, then prediction of the newly accepted transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                res_taken = 1'b1;
                if (outcomes_due.size() == 0)
                begin
                    report_mismatch("unexpected result, status", m_tuser, -1);
                end
                else
                begin
                    due = outcomes_due.pop_front();
                    if (m_tuser !== due.status)
                        report_mismatch("status", m_tuser, due.status);
                    if (m_tdata[2:0] !== due.flags)
                        report_mismatch("flags_out", m_tdata[2:0], due.flags);
                    if ($signed(m_tdata[21:3]) !== due.free_bytes)
                        report_mismatch("free_bytes", $signed(m_tdata[21:3]), due.free_bytes);
                    if (m_tdata[37:22] !== due.lock_offset)
                        report_mismatch("lock_offset", m_tdata[37:22], due.lock_offset);
                    if (m_tdata[54:38] !== due.lock_length)
                        report_mismatch("lock_length", m_tdata[54:38], due.lock_length);
                    if (m_tdata[58:55] !== due.total)
                        report_mismatch("allocated_total", m_tdata[58:55], due.total);
                end
            end
            if (s_tvalid && s_tready)
            begin
                op_taken = 1'b1;
                outcomes_due.push_back(apply_op(op_now));
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < NUM_STREAMS; i++)
        begin
            trk_flags[i] = '0;
            trk_size[i]  = 0;
            trk_woff[i]  = 0;
            trk_poff[i]  = 0;
            trk_pend[i]  = 0;
            trk_llen[i]  = 0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_stream_count(4'd8);
        add_op(OP_FLAGS, 0, 0, 0, 0);
        add_op(OP_FREE, 1, 0, 0, 0);
        add_op(OP_ALLOC, 0, 100000, 0, 0);
        add_op(OP_ALLOC, 0, 100, 0, 0);
        add_op(OP_LOCK, 0, 0, 131071, 0);
        add_op(OP_LOCK, 0, 0, 10, 0);
        add_op(OP_UNLOCK, 0, 0, 0, 0);
        // pending count runs into its upper bound
        repeat (3)
        begin
            add_op(OP_LOCK, 0, 0, 65536, 0);
            add_op(OP_UNLOCK, 0, 0, 0, 0);
        end
        add_op(OP_SPACE, 0, 0, 0, 65535);
        add_op(OP_SPACE, 0, 0, 0, 0);
        add_op(OP_STOP, 0, 0, 0, 0);
        add_op(OP_ALLOC, 2, 16, 0, 0);
        add_op(OP_SPACE, 2, 0, 0, 10);
        add_op(OP_SPACE, 2, 0, 0, 3);
        add_op(OP_PLAY, 2, 0, 0, 0);
        add_op(OP_PLAY, 2, 0, 0, 0);
        add_op(OP_PREPARE, 2, 0, 0, 0);
        add_op(OP_FREE, 2, 0, 0, 0);
        add_op(OP_UNLOCK, 0, 0, 0, 0);
        // free and realloc while locked, then a write offset past the end
        add_op(OP_LOCK, 0, 0, 5, 0);
        add_op(OP_FREE, 0, 0, 0, 0);
        add_op(OP_ALLOC, 0, 0, 0, 0);
        add_op(OP_UNLOCK, 0, 0, 0, 0);
        add_op(OP_LOCK, 0, 0, 3, 0);
        add_op(4'd15, 0, 0, 0, 0);
        wait_drained();

        stall_request = 1'b1;
        add_random_ops(300, 8);
        wait_drained();

        set_stream_count(4'd0);
        add_random_ops(30, 0);
        wait_drained();

        set_stream_count(4'd1);
        max_wait = 0;
        add_random_ops(150, 1);
        wait_drained();
        max_wait = 8;

        set_stream_count(4'd5);
        add_random_ops(220, 5);
        wait_drained();

        set_stream_count(4'd8);
        add_random_ops(300, 8);
        wait_drained();

        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
src/srbt_pkg.sv
src/srbt_ram.sv
src/srbt_alu.sv
src/stream_ring_buffer_tracker.sv
bench/stream_ring_buffer_tracker_test.sv
